// ===== hw/rtl/directional_class_filter_upscaler_macros.svh =====
// assertion macros shared by the directional class filter upscaler rtl
`ifndef DIRECTIONAL_CLASS_FILTER_UPSCALER_MACROS_SVH
`define DIRECTIONAL_CLASS_FILTER_UPSCALER_MACROS_SVH

// clocked assertion on clk, disabled during rst
`define DCFU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define DCFU_ASSERT_IMP(label, ante, cons, msg) \
  `DCFU_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/dcfu_pkg.sv =====
// shared constants and types of the directional class filter upscaler
package dcfu_pkg;

  localparam int RADIUS_DEF    = 2;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int COEF_BITS_DEF = 18;
  localparam int FRAC_BITS_DEF = 14;

  localparam int NCLASS   = 625;
  localparam int NPHASE   = 4;
  localparam int PIX_W    = 24;
  localparam int ROW_MAX  = 2047;

  // register indexes
  localparam logic [1:0] REG_UPSCALE   = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam logic       UPSCALE_RESET   = 1'b1;
  localparam logic [11:0] WIDTH_RESET    = 12'd2048;
  localparam logic [18:0] THRESHOLD_RESET = 19'd225;

  typedef struct packed {
    logic        valid;
    logic [9:0]  cls;
    logic [1:0]  ph;
    logic        last;
  } issue_t;

  typedef struct packed {
    logic               en;
    logic [9:0]         cls;
    logic [1:0]         ph;
    logic [5:0]         tap;
    logic signed [31:0] value;
  } coef_wr_t;

endpackage

// ===== hw/rtl/directional_class_filter_upscaler.sv =====
// top level of the directional class filter upscaler
//
// streams a padded yuv raster in raster order (tuser 1) or kernel
// coefficients (tuser 0) and returns filtered pixels. an input transfer can
// be taken every cycle while the output does not stall and no phases remain;
// each pixel with a full window then gives four results in upscale mode (one
// per phase) and one in deblur mode. the single coefficient read port of the
// kernel store yields one phase kernel per cycle while the output does not
// stall. pixels whose window is incomplete and coefficient loads give no
// result. line stores, window and coefficient store hold no defined value
// until written.
`include "directional_class_filter_upscaler_macros.svh"
module directional_class_filter_upscaler #(
  parameter int RADIUS    = dcfu_pkg::RADIUS_DEF,
  parameter int MAX_WIDTH = dcfu_pkg::MAX_WIDTH_DEF,
  parameter int COEF_BITS = dcfu_pkg::COEF_BITS_DEF,
  parameter int FRAC_BITS = dcfu_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // coef_class[9:0] coef_phase[11:10] coef_tap[17:12] coef_value[35:18]
  // pixel_y[43:36] pixel_u[51:44] pixel_v[59:52] frame_start[60]
  input  logic [63:0] s_tdata,
  // mode[0]
  input  logic        s_tuser,
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_y[7:0] out_u[15:8] out_v[23:16] phase[25:24]
  output logic [31:0] m_tdata,
  output logic        m_tlast,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WIN   = 2 * RADIUS + 1;
  localparam int TAPS  = WIN * WIN;
  localparam int LINES = 2 * RADIUS;
  localparam int LW    = $clog2(LINES);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int PXW   = dcfu_pkg::PIX_W;
  localparam int WINW  = TAPS * PXW;

  // configuration registers
  logic        upscale_mode;
  logic [11:0] line_width;
  logic [18:0] gradient_threshold;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upscale_mode       <= dcfu_pkg::UPSCALE_RESET;
      line_width         <= dcfu_pkg::WIDTH_RESET;
      gradient_threshold <= dcfu_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        dcfu_pkg::REG_UPSCALE:   upscale_mode       <= pwdata[0];
        dcfu_pkg::REG_WIDTH:     line_width         <= pwdata[11:0];
        dcfu_pkg::REG_THRESHOLD: gradient_threshold <= pwdata[18:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      dcfu_pkg::REG_UPSCALE:   prdata = {31'd0, upscale_mode};
      dcfu_pkg::REG_WIDTH:     prdata = {20'd0, line_width};
      dcfu_pkg::REG_THRESHOLD: prdata = {13'd0, gradient_threshold};
      default:                 prdata = 32'd0;
    endcase
  end

  // pipeline control: back end moves when the output register frees,
  // front end also waits for the phase issue stage to finish its item
  logic run, front_adv, accept, acc_pix;
  logic p4_done;

  assign run       = !m_tvalid || m_tready;
  assign front_adv = run && p4_done;
  assign s_tready  = front_adv;
  assign accept    = s_tvalid && s_tready;
  assign acc_pix   = accept && s_tuser;

  // input fields
  logic [9:0]  in_cls;
  logic [1:0]  in_ph;
  logic [5:0]  in_tap;
  logic signed [17:0] in_coef;
  logic [PXW-1:0] in_pix;
  logic        in_fs;

  assign in_cls  = s_tdata[9:0];
  assign in_ph   = s_tdata[11:10];
  assign in_tap  = s_tdata[17:12];
  assign in_coef = signed'(s_tdata[35:18]);
  assign in_pix  = s_tdata[59:36];
  assign in_fs   = s_tdata[60];

  // raster position
  logic [CW-1:0] col;
  logic [LW-1:0] ring;
  logic [10:0]   row;
  logic [CW-1:0] col_cur;
  logic [LW-1:0] ring_cur;
  logic [10:0]   row_cur;
  logic [CW:0]   col_inc;
  logic [13:0]   width_eff;
  logic          complete;

  always_comb begin
    if (line_width < 12'(WIN))              width_eff = 14'(WIN);
    else if (14'(line_width) > 14'(MAX_WIDTH)) width_eff = 14'(MAX_WIDTH);
    else                                     width_eff = 14'(line_width);
    col_cur  = in_fs ? '0 : col;
    ring_cur = in_fs ? '0 : ring;
    row_cur  = in_fs ? '0 : row;
    col_inc  = {1'b0, col_cur} + 1'b1;
    complete = (row_cur >= 11'(LINES)) && (col_cur >= CW'(LINES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      ring <= '0;
      row  <= '0;
    end else if (acc_pix) begin
      if (15'(col_inc) >= 15'(width_eff)) begin
        col  <= '0;
        ring <= (ring_cur == LW'(LINES - 1)) ? '0 : ring_cur + 1'b1;
        row  <= (row_cur < 11'(dcfu_pkg::ROW_MAX)) ? row_cur + 1'b1 : row_cur;
      end else begin
        col  <= col_inc[CW-1:0];
        ring <= ring_cur;
        row  <= row_cur;
      end
    end
  end

  // line stores, one per stored line, read before write
  logic [PXW-1:0] lrd [LINES];

  for (genvar m = 0; m < LINES; m++) begin : g_line
    logic [PXW-1:0] lmem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (acc_pix) begin
        lrd[m] <= lmem[col_cur];
        if (ring_cur == LW'(m)) lmem[col_cur] <= in_pix;
      end
    end
  end

  // s0: accepted transfer
  logic        s0_v, s0_pix, s0_cmp;
  logic [LW-1:0] s0_ring;
  logic [PXW-1:0] s0_pixel;
  dcfu_pkg::coef_wr_t s0_cw;

  always_ff @(posedge clk) begin
    if (rst) s0_v <= 1'b0;
    else if (front_adv) s0_v <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_pix   <= s_tuser;
      s0_cmp   <= complete;
      s0_ring  <= ring_cur;
      s0_pixel <= in_pix;
      s0_cw.en    <= !s_tuser && (in_cls < 10'(dcfu_pkg::NCLASS)) && (in_tap < 6'(TAPS));
      s0_cw.cls   <= in_cls;
      s0_cw.ph    <= in_ph;
      s0_cw.tap   <= in_tap;
      s0_cw.value <= 32'(in_coef);
    end
  end

  // s1: window shift, newest column on the right, newest row at the bottom
  logic [PXW-1:0] wreg [WIN][WIN];
  logic [PXW-1:0] colv [WIN];
  logic           s1_v, s1_pix, s1_cmp;
  dcfu_pkg::coef_wr_t s1_cw;

  always_comb begin
    logic [LW:0] idx;
    for (int k = 0; k < LINES; k++) begin
      idx = (LW+1)'(s0_ring) + (LW+1)'(k);
      if (idx >= (LW+1)'(LINES)) idx = idx - (LW+1)'(LINES);
      colv[k] = lrd[idx[LW-1:0]];
    end
    colv[LINES] = s0_pixel;
  end

  always_ff @(posedge clk) begin
    if (front_adv && s0_v && s0_pix) begin
      for (int j = 0; j < WIN; j++) begin
        for (int i = 0; i < WIN - 1; i++) wreg[j][i] <= wreg[j][i+1];
        wreg[j][WIN-1] <= colv[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (front_adv) s1_v <= s0_v;
  end

  always_ff @(posedge clk) begin
    if (front_adv) begin
      s1_pix <= s0_pix;
      s1_cmp <= s0_cmp;
      s1_cw  <= s0_cw;
    end
  end

  logic [WINW-1:0] win_flat;
  logic [71:0]     luma;

  always_comb begin
    for (int j = 0; j < WIN; j++)
      for (int i = 0; i < WIN; i++) win_flat[(j*WIN+i)*PXW +: PXW] = wreg[j][i];
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) luma[(r*3+c)*8 +: 8] = wreg[RADIUS-1+r][RADIUS-1+c][7:0];
  end

  // s2..s4: classification alongside window copies
  logic [9:0] cls;

  dcfu_classify u_classify (
    .clk       (clk),
    .en        (front_adv),
    .luma      (luma),
    .threshold (gradient_threshold),
    .cls       (cls)
  );

  logic [2:0] pv;
  logic       pp [3];
  logic       pc [3];
  dcfu_pkg::coef_wr_t pcw [3];
  logic [WINW-1:0] pw [3];

  always_ff @(posedge clk) begin
    if (rst) pv <= '0;
    else if (front_adv) pv <= {pv[1:0], s1_v};
  end

  always_ff @(posedge clk) begin
    if (front_adv) begin
      pp[0] <= s1_pix;  pc[0] <= s1_cmp;  pcw[0] <= s1_cw;  pw[0] <= win_flat;
      for (int s = 1; s < 3; s++) begin
        pp[s] <= pp[s-1]; pc[s] <= pc[s-1]; pcw[s] <= pcw[s-1]; pw[s] <= pw[s-1];
      end
    end
  end

  // s4: phase issue
  logic [1:0] ph;
  logic       p4_issue, iss_last;
  dcfu_pkg::issue_t   iss;
  dcfu_pkg::coef_wr_t cw;

  assign p4_issue = pv[2] && pp[2] && pc[2];
  assign iss_last = upscale_mode ? (ph == 2'd3) : 1'b1;
  assign p4_done  = !p4_issue || iss_last;

  always_ff @(posedge clk) begin
    if (rst) ph <= '0;
    else if (run && p4_issue) ph <= iss_last ? 2'd0 : ph + 2'd1;
  end

  always_comb begin
    iss.valid = run && p4_issue;
    iss.cls   = cls;
    iss.ph    = ph;
    iss.last  = iss_last;
    cw        = pcw[2];
    cw.en     = run && pv[2] && !pp[2] && pcw[2].en;
  end

  // s5..s8: kernel read, products, sums, rounding into the output register
  logic       f_last;
  logic [1:0] f_phase;
  logic [7:0] f_y, f_u, f_v;

  dcfu_filter #(
    .RADIUS    (RADIUS),
    .COEF_BITS (COEF_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_filter (
    .clk   (clk),
    .rst   (rst),
    .run   (run),
    .cw    (cw),
    .iss   (iss),
    .win   (pw[2]),
    .valid (m_tvalid),
    .last  (f_last),
    .phase (f_phase),
    .out_y (f_y),
    .out_u (f_u),
    .out_v (f_v)
  );

  assign m_tdata = {6'd0, f_phase, f_v, f_u, f_y};
  assign m_tlast = f_last;

  // a non-final phase keeps the input closed
  `DCFU_ASSERT_IMP(a_issue_blocks_input, p4_issue && !iss_last, !s_tready,
                   "input taken while phases remain")
  // a phase count in flight implies an item at the issue stage
  `DCFU_ASSERT_IMP(a_phase_has_item, ph != 2'd0, pv[2] && p4_issue,
                   "phase counter running without an item")
  // deblur results are single and phase zero
  `DCFU_ASSERT_IMP(a_deblur_single, m_tvalid && !upscale_mode,
                   m_tlast && f_phase == 2'd0, "deblur result not single")

endmodule

// ===== hw/rtl/dcfu_classify.sv =====
// three-stage luma gradient classifier giving the base-5 class of a window
module dcfu_classify (
  input  logic        clk,
  input  logic        en,
  input  logic [71:0] luma,        // 3x3 centre luma, row major, lowest first
  input  logic [18:0] threshold,
  output logic [9:0]  cls
);

  logic signed [10:0] dx [4];
  logic signed [10:0] dy [4];
  logic [20:0] g  [4];
  logic [20:0] s1 [4];
  logic [20:0] s2 [4];
  logic [20:0] s3 [4];
  logic [20:0] s4 [4];
  logic [2:0]  dir [4];

  function automatic logic signed [10:0] lum(input logic [71:0] l, input int idx);
    lum = signed'({3'b000, l[idx*8 +: 8]});
  endfunction

  // stage a: block differences
  always_ff @(posedge clk) begin
    if (en) begin
      for (int b = 0; b < 4; b++) begin
        dx[b] <= lum(luma, (b/2)*3 + b%2) + lum(luma, (b/2+1)*3 + b%2)
               - lum(luma, (b/2)*3 + b%2 + 1) - lum(luma, (b/2+1)*3 + b%2 + 1);
        dy[b] <= lum(luma, (b/2)*3 + b%2) + lum(luma, (b/2)*3 + b%2 + 1)
               - lum(luma, (b/2+1)*3 + b%2) - lum(luma, (b/2+1)*3 + b%2 + 1);
      end
    end
  end

  // stage b: squared magnitudes
  always_ff @(posedge clk) begin
    logic signed [21:0] pxx, pyy, pd, ps;
    if (en) begin
      for (int b = 0; b < 4; b++) begin
        pxx = dx[b] * dx[b];
        pyy = dy[b] * dy[b];
        pd  = (dx[b] - dy[b]) * (dx[b] - dy[b]);
        ps  = (dx[b] + dy[b]) * (dx[b] + dy[b]);
        g[b]  <= pxx[20:0] + pyy[20:0];
        s1[b] <= {pyy[19:0], 1'b0};
        s2[b] <= pd[20:0];
        s3[b] <= {pxx[19:0], 1'b0};
        s4[b] <= ps[20:0];
      end
    end
  end

  // stage c: direction pick and class
  always_comb begin
    logic [20:0] m12, m34;
    logic [2:0]  r12, r34;
    for (int b = 0; b < 4; b++) begin
      if (s1[b] < s2[b]) begin
        m12 = s2[b]; r12 = 3'd2;
      end else begin
        m12 = s1[b]; r12 = 3'd1;
      end
      if (s3[b] < s4[b]) begin
        m34 = s4[b]; r34 = 3'd4;
      end else begin
        m34 = s3[b]; r34 = 3'd3;
      end
      if (g[b] <= {2'b00, threshold}) dir[b] = 3'd0;
      else                           dir[b] = (m12 < m34) ? r34 : r12;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cls <= 10'(dir[3]) * 10'd125 + 10'(dir[2]) * 10'd25 + 10'(dir[1]) * 10'd5
           + 10'(dir[0]);
    end
  end

endmodule

// ===== hw/rtl/dcfu_filter.sv =====
// coefficient store and pipelined yuv kernel filter, one phase per cycle while run is high
module dcfu_filter #(
  parameter int RADIUS    = dcfu_pkg::RADIUS_DEF,
  parameter int COEF_BITS = dcfu_pkg::COEF_BITS_DEF,
  parameter int FRAC_BITS = dcfu_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               run,
  input  dcfu_pkg::coef_wr_t cw,
  input  dcfu_pkg::issue_t   iss,
  input  logic [(2*RADIUS+1)*(2*RADIUS+1)*dcfu_pkg::PIX_W-1:0] win,
  output logic               valid,
  output logic               last,
  output logic [1:0]         phase,
  output logic [7:0]         out_y,
  output logic [7:0]         out_u,
  output logic [7:0]         out_v
);

  localparam int WIN   = 2 * RADIUS + 1;
  localparam int TAPS  = WIN * WIN;
  localparam int DEPTH = dcfu_pkg::NCLASS * dcfu_pkg::NPHASE;
  localparam int PW    = COEF_BITS + 9;
  localparam int RW    = PW + 3;
  localparam int AW    = PW + 6;

  logic [COEF_BITS-1:0] crd [TAPS];
  logic [11:0] waddr, raddr;

  assign waddr = {cw.cls, cw.ph};
  assign raddr = {iss.cls, iss.ph};

  for (genvar t = 0; t < TAPS; t++) begin : g_tap
    logic [COEF_BITS-1:0] cmem [DEPTH];
    always_ff @(posedge clk) begin
      if (cw.en && cw.tap == 6'(t)) cmem[waddr] <= cw.value[COEF_BITS-1:0];
      if (run) crd[t] <= cmem[raddr];
    end
  end

  // f1: coefficients read, window copy
  logic f1_v, f1_last;
  logic [1:0] f1_ph;
  logic [TAPS*dcfu_pkg::PIX_W-1:0] f1_win;

  // f2: products
  logic f2_v, f2_last;
  logic [1:0] f2_ph;
  logic signed [PW-1:0] pr [3][TAPS];

  // f3: row sums
  logic f3_v, f3_last;
  logic [1:0] f3_ph;
  logic signed [RW-1:0] rs [3][WIN];

  logic [7:0] res [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v  <= 1'b0;
      f2_v  <= 1'b0;
      f3_v  <= 1'b0;
      valid <= 1'b0;
    end else if (run) begin
      f1_v  <= iss.valid;
      f2_v  <= f1_v;
      f3_v  <= f2_v;
      valid <= f3_v;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [RW-1:0] rsum;
    if (run) begin
      f1_last <= iss.last;
      f1_ph   <= iss.ph;
      f1_win  <= win;
      f2_last <= f1_last;
      f2_ph   <= f1_ph;
      for (int c = 0; c < 3; c++)
        for (int t = 0; t < TAPS; t++)
          pr[c][t] <= signed'(crd[t])
                    * signed'({1'b0, f1_win[t*dcfu_pkg::PIX_W + c*8 +: 8]});
      f3_last <= f2_last;
      f3_ph   <= f2_ph;
      for (int c = 0; c < 3; c++)
        for (int r = 0; r < WIN; r++) begin
          rsum = '0;
          for (int i = 0; i < WIN; i++) rsum = rsum + RW'(pr[c][r*WIN+i]);
          rs[c][r] <= rsum;
        end
      last  <= f3_last;
      phase <= f3_ph;
      out_y <= res[0];
      out_u <= res[1];
      out_v <= res[2];
    end
  end

  // total, round half up, saturate to a byte
  always_comb begin
    logic signed [AW:0] acc;
    for (int c = 0; c < 3; c++) begin
      acc = (AW+1)'(1) <<< (FRAC_BITS - 1);
      for (int r = 0; r < WIN; r++) acc = acc + (AW+1)'(rs[c][r]);
      if (acc < 0)                          res[c] = 8'd0;
      else if ((acc >>> FRAC_BITS) > 255)   res[c] = 8'd255;
      else                                  res[c] = 8'(acc >>> FRAC_BITS);
    end
  end

endmodule
